@@ hw/rtl/lcdseq_pkg.sv @@
// lcdseq_pkg: shared types, codes and byte builders for the character-lcd sequencer
// used by every module of the block; depends on nothing
package lcdseq_pkg;

    // request codes
    localparam logic [3:0] MODE_CHAR      = 4'd0;
    localparam logic [3:0] MODE_CLEAR     = 4'd1;
    localparam logic [3:0] MODE_CUR_SHIFT = 4'd2;
    localparam logic [3:0] MODE_DSP_SHIFT = 4'd3;
    localparam logic [3:0] MODE_ADDRESS   = 4'd4;
    localparam logic [3:0] MODE_LINE      = 4'd5;
    localparam logic [3:0] MODE_DSP_CTL   = 4'd6;
    localparam logic [3:0] MODE_ENTRY     = 4'd7;
    localparam logic [3:0] MODE_FUNCTION  = 4'd8;
    localparam logic [3:0] MODE_RESET     = 4'd9;
    localparam logic [3:0] MODE_INIT      = 4'd10;

    // configuration register indexes
    localparam logic [3:0] CFG_TWO_LINE   = 4'd0;
    localparam logic [3:0] CFG_FONT_5X10  = 4'd1;
    localparam logic [3:0] CFG_DISPLAY_ON = 4'd2;
    localparam logic [3:0] CFG_CURSOR_ON  = 4'd3;
    localparam logic [3:0] CFG_BLINK      = 4'd4;
    localparam logic [3:0] CFG_INCREMENT  = 4'd5;
    localparam logic [3:0] CFG_SHIFT      = 4'd6;
    localparam logic [3:0] CFG_HOLD_MS    = 4'd7;

    // instruction bytes
    localparam logic [7:0] INS_CLEAR      = 8'b0000_0001;
    localparam logic [7:0] INS_ENTRY      = 8'b0000_0100;
    localparam logic [7:0] INS_DSP_CTL    = 8'b0000_1000;
    localparam logic [7:0] INS_CUR_SHIFT  = 8'b0001_0000;
    localparam logic [7:0] INS_DSP_SHIFT  = 8'b0001_1000;
    localparam logic [7:0] INS_FUNCTION   = 8'b0010_0000;
    localparam logic [7:0] INS_SET_ADDR   = 8'b1000_0000;
    localparam logic [7:0] LINE2_ADDR     = 8'h40;

    // wake-up nibbles and waits
    localparam logic [3:0] WAKE_NIB       = 4'b0011;
    localparam logic [3:0] WAKE_NIB_LAST  = 4'b0010;
    localparam logic [7:0] WAKE_WAIT_LONG = 8'd100;
    localparam logic [7:0] WAKE_WAIT_SHORT = 8'd1;

    // sequencer step map: dummy pulse, wake-up pulses, byte pulses
    localparam logic [4:0] STEP_DUMMY     = 5'd0;
    localparam logic [4:0] STEP_WAKE      = 5'd2;
    localparam logic [4:0] STEP_WAKE_END  = 5'd9;
    localparam logic [4:0] STEP_BYTE      = 5'd10;
    localparam logic [4:0] STEP_BYTE_END  = 5'd13;
    localparam logic [4:0] STEP_INIT_END  = 5'd25;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] char_code;
        logic [6:0] ram_address;
        logic       right_shift;
        logic       line_number;
    } t_req;

    typedef struct packed {
        logic [7:0] wait_before_ms;
        logic       reg_select;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       last_event;
    } t_evt;

    typedef struct packed {
        logic       two_line;
        logic       font_5x10;
        logic       display_on;
        logic       cursor_on;
        logic       cursor_blink;
        logic       increment_on_entry;
        logic       shift_on_entry;
        logic [7:0] pulse_hold_ms;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_WAKE = 2'd1,
        CMD_INIT = 2'd2
    } t_kind;

    // one classified request as held in the queue
    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [7:0] func_byte(input t_cfg cfg);
        func_byte = INS_FUNCTION | {4'b0, cfg.two_line, cfg.font_5x10, 2'b0};
    endfunction

    function automatic logic [7:0] disp_byte(input t_cfg cfg);
        disp_byte = INS_DSP_CTL | {5'b0, cfg.display_on, cfg.cursor_on, cfg.cursor_blink};
    endfunction

    function automatic logic [7:0] entry_byte(input t_cfg cfg);
        entry_byte = INS_ENTRY | {6'b0, cfg.increment_on_entry, cfg.shift_on_entry};
    endfunction

endpackage

@@ hw/rtl/lcdseq_front.sv @@
// lcdseq_front: decodes a request into a queued command (byte, wake-up or init)
// depends on lcdseq_pkg
module lcdseq_front (
    input  lcdseq_pkg::t_req i_req,
    input  lcdseq_pkg::t_cfg i_cfg,
    output logic             o_push_ok,
    output lcdseq_pkg::t_cmd o_cmd
);

    // instruction or data byte per request code
    always_comb begin
        o_push_ok  = 1'b1;
        o_cmd.kind = lcdseq_pkg::CMD_BYTE;
        o_cmd.rs   = 1'b0;
        o_cmd.data = 8'h00;
        unique case (i_req.mode)
            lcdseq_pkg::MODE_CHAR: begin
                o_cmd.rs   = 1'b1;
                o_cmd.data = i_req.char_code;
            end
            lcdseq_pkg::MODE_CLEAR:
                o_cmd.data = lcdseq_pkg::INS_CLEAR;
            lcdseq_pkg::MODE_CUR_SHIFT:
                o_cmd.data = lcdseq_pkg::INS_CUR_SHIFT | {5'b0, i_req.right_shift, 2'b0};
            lcdseq_pkg::MODE_DSP_SHIFT:
                o_cmd.data = lcdseq_pkg::INS_DSP_SHIFT | {5'b0, i_req.right_shift, 2'b0};
            lcdseq_pkg::MODE_ADDRESS:
                o_cmd.data = lcdseq_pkg::INS_SET_ADDR | {1'b0, i_req.ram_address};
            lcdseq_pkg::MODE_LINE:
                o_cmd.data = i_req.line_number
                           ? (lcdseq_pkg::INS_SET_ADDR | lcdseq_pkg::LINE2_ADDR)
                           : lcdseq_pkg::INS_SET_ADDR;
            lcdseq_pkg::MODE_DSP_CTL:
                o_cmd.data = lcdseq_pkg::disp_byte(i_cfg);
            lcdseq_pkg::MODE_ENTRY:
                o_cmd.data = lcdseq_pkg::entry_byte(i_cfg);
            lcdseq_pkg::MODE_FUNCTION:
                o_cmd.data = lcdseq_pkg::func_byte(i_cfg);
            lcdseq_pkg::MODE_RESET:
                o_cmd.kind = lcdseq_pkg::CMD_WAKE;
            lcdseq_pkg::MODE_INIT:
                o_cmd.kind = lcdseq_pkg::CMD_INIT;
            // undefined codes are swallowed without events
            default:
                o_push_ok = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/lcdseq_queue.sv @@
// lcdseq_queue: small flop-based command fifo between decoder and sequencer
// depends on lcdseq_pkg
module lcdseq_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdseq_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lcdseq_pkg::t_cmd o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcdseq_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/lcdseq_back.sv @@
// lcdseq_back: step sequencer turning queued commands into pin events, with output register
// depends on lcdseq_pkg
module lcdseq_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lcdseq_pkg::t_cfg i_cfg,
    input  logic             i_empty,
    input  lcdseq_pkg::t_cmd i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output lcdseq_pkg::t_evt o_data
);

    logic             r_active, n_active;
    logic [4:0]       r_step, n_step;
    logic             r_rs, n_rs;
    logic [3:0]       r_nib, n_nib;
    logic             r_out_valid;
    lcdseq_pkg::t_evt r_out;

    logic             w_load;
    logic             w_emit;
    logic [4:0]       w_start, w_end, w_step;
    logic [2:0]       w_wake_idx;
    logic [3:0]       w_byte_idx;
    logic [7:0]       w_byte;
    lcdseq_pkg::t_evt w_evt;

    assign w_load  = !r_out_valid || !i_stall;
    assign w_emit  = w_load && !i_empty;
    assign o_pop   = w_emit && (w_step == w_end);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // step range per command kind
    always_comb begin
        unique case (i_head.kind)
            lcdseq_pkg::CMD_WAKE: begin
                w_start = lcdseq_pkg::STEP_WAKE;
                w_end   = lcdseq_pkg::STEP_WAKE_END;
            end
            lcdseq_pkg::CMD_INIT: begin
                w_start = lcdseq_pkg::STEP_DUMMY;
                w_end   = lcdseq_pkg::STEP_INIT_END;
            end
            default: begin
                w_start = lcdseq_pkg::STEP_BYTE;
                w_end   = lcdseq_pkg::STEP_BYTE_END;
            end
        endcase
    end

    assign w_step     = r_active ? r_step : w_start;
    assign w_wake_idx = 3'(w_step - lcdseq_pkg::STEP_WAKE);
    assign w_byte_idx = 4'(w_step - lcdseq_pkg::STEP_BYTE);

    // byte for the current transfer: queued byte, or one of the init bytes
    always_comb begin
        if (i_head.kind != lcdseq_pkg::CMD_INIT) begin
            w_byte = i_head.data;
        end else begin
            case (w_byte_idx[3:2])
                2'd0:    w_byte = lcdseq_pkg::func_byte(i_cfg);
                2'd1:    w_byte = lcdseq_pkg::INS_CLEAR;
                2'd2:    w_byte = lcdseq_pkg::disp_byte(i_cfg);
                default: w_byte = lcdseq_pkg::entry_byte(i_cfg);
            endcase
        end
    end

    // pin event for the current step
    always_comb begin
        w_evt.last_event = (w_step == w_end);
        if (w_step < lcdseq_pkg::STEP_WAKE) begin
            // dummy pulse keeps the present bus levels
            w_evt.reg_select     = r_rs;
            w_evt.data_nibble    = r_nib;
            w_evt.enable_pin     = !w_step[0];
            w_evt.wait_before_ms = w_step[0] ? i_cfg.pulse_hold_ms : 8'd0;
        end else if (w_step < lcdseq_pkg::STEP_BYTE) begin
            w_evt.reg_select  = 1'b0;
            w_evt.data_nibble = (w_wake_idx[2:1] == 2'd3) ? lcdseq_pkg::WAKE_NIB_LAST
                                                           : lcdseq_pkg::WAKE_NIB;
            w_evt.enable_pin  = !w_wake_idx[0];
            if (w_wake_idx[0]) begin
                w_evt.wait_before_ms = i_cfg.pulse_hold_ms;
            end else if (w_wake_idx[2:1] == 2'd0) begin
                w_evt.wait_before_ms = lcdseq_pkg::WAKE_WAIT_LONG;
            end else if (w_wake_idx[2:1] == 2'd3) begin
                w_evt.wait_before_ms = 8'd0;
            end else begin
                w_evt.wait_before_ms = lcdseq_pkg::WAKE_WAIT_SHORT;
            end
        end else begin
            // high nibble pulse, then low nibble pulse
            w_evt.reg_select     = (i_head.kind == lcdseq_pkg::CMD_BYTE) ? i_head.rs : 1'b0;
            w_evt.data_nibble    = w_byte_idx[1] ? w_byte[3:0] : w_byte[7:4];
            w_evt.enable_pin     = !w_byte_idx[0];
            w_evt.wait_before_ms = w_byte_idx[0] ? i_cfg.pulse_hold_ms : 8'd0;
        end
    end

    // sequencer and pin level tracking
    always_comb begin
        n_active = r_active;
        n_step   = r_step;
        n_rs     = r_rs;
        n_nib    = r_nib;
        if (w_emit) begin
            n_rs  = w_evt.reg_select;
            n_nib = w_evt.data_nibble;
            if (w_step == w_end) begin
                n_active = 1'b0;
            end else begin
                n_active = 1'b1;
                n_step   = w_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= '0;
            r_rs        <= 1'b0;
            r_nib       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_step   <= n_step;
            r_rs     <= n_rs;
            r_nib    <= n_nib;
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_evt;
        end
    end

endmodule

@@ hw/rtl/lcdseq_top.sv @@
// lcd_char_4bit_bus_sequencer_top: configuration registers, decoder, command queue, sequencer
// depends on lcdseq_pkg, lcdseq_front, lcdseq_queue, lcdseq_back
//
// Character-LCD 4-bit bus sequencer. Each accepted request word becomes a run of
// pin event words (RS, E, D7..D4 and a wait in ms), the last one flagged. The sequencer
// emits one event per clock while the output is not stalled: 4 for a byte request, 8
// for a reset and 26 for a full init; unused request codes produce nothing. A
// QUEUE_DEPTH-entry command queue sits between decoder and sequencer, so requests are
// taken while events drain until it fills; the output register holds a stalled event.
// Configuration writes are always ready and should be made while idle.
module lcd_char_4bit_bus_sequencer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lcdseq_pkg::t_req i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lcdseq_pkg::t_evt o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [3:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    lcdseq_pkg::t_cfg r_cfg;
    lcdseq_pkg::t_cmd w_cmd, w_head;
    logic             w_push_ok, w_full, w_empty, w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.two_line           <= 1'b1;
            r_cfg.font_5x10          <= 1'b0;
            r_cfg.display_on         <= 1'b1;
            r_cfg.cursor_on          <= 1'b1;
            r_cfg.cursor_blink       <= 1'b1;
            r_cfg.increment_on_entry <= 1'b1;
            r_cfg.shift_on_entry     <= 1'b0;
            r_cfg.pulse_hold_ms      <= 8'd5;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcdseq_pkg::CFG_TWO_LINE:   r_cfg.two_line           <= i_cfg_data[0];
                lcdseq_pkg::CFG_FONT_5X10:  r_cfg.font_5x10          <= i_cfg_data[0];
                lcdseq_pkg::CFG_DISPLAY_ON: r_cfg.display_on         <= i_cfg_data[0];
                lcdseq_pkg::CFG_CURSOR_ON:  r_cfg.cursor_on          <= i_cfg_data[0];
                lcdseq_pkg::CFG_BLINK:      r_cfg.cursor_blink       <= i_cfg_data[0];
                lcdseq_pkg::CFG_INCREMENT:  r_cfg.increment_on_entry <= i_cfg_data[0];
                lcdseq_pkg::CFG_SHIFT:      r_cfg.shift_on_entry     <= i_cfg_data[0];
                lcdseq_pkg::CFG_HOLD_MS:    r_cfg.pulse_hold_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request decoder
    lcdseq_front u_front (
        .i_req     (i_in_data),
        .i_cfg     (r_cfg),
        .o_push_ok (w_push_ok),
        .o_cmd     (w_cmd)
    );

    // command queue
    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && w_push_ok),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // pin event sequencer
    lcdseq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
